// ===== hw/rtl/ahdlc_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the async HDLC framer/deframer.
// Depends on nothing; the front, queue, back and top files refer to it by scoped names.
package ahdlc_pkg;

  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [7:0]  ESC_BYTE  = 8'h7D;
  localparam logic [7:0]  ESC_XOR   = 8'h20;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'h8408;

  // Job queue between the front and back parts.
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef enum logic [1:0] {
    JOB_TX,
    JOB_RX_BYTE,
    JOB_RX_END
  } job_kind_t;

  typedef enum logic [1:0] {
    PH_DATA,
    PH_FCS_LO,
    PH_FCS_HI,
    PH_FLAG
  } tx_phase_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [7:0]  data;
    logic        last;
    logic [15:0] fcs;
  } job_t;

  // Reflected CRC-16, one byte folded in bit by bit.
  function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/ahdlc_if.sv =====
// Valid/ready channel interfaces for the input items and the result items.
// Depends on nothing.
interface ahdlc_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;
  logic       frame_last;

  modport source (output valid, output mode, output data_byte, output frame_last,
                  input ready);
  modport sink   (input valid, input mode, input data_byte, input frame_last,
                  output ready);
endinterface

interface ahdlc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;
  logic       run_last;

  modport source (output valid, output out_byte, output frame_end, output run_last,
                  input ready);
  modport sink   (input valid, input out_byte, input frame_end, input run_last,
                  output ready);
endinterface

// ===== hw/rtl/ahdlc_front.sv =====
// Front part: accepts items, updates CRC and receive state, and issues jobs.
// Depends on ahdlc_pkg.
module ahdlc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_mode,
  input  logic [7:0]        in_data,
  input  logic              in_last,
  input  logic              q_ready,
  output logic              in_ready,
  output logic              push,
  output ahdlc_pkg::job_t   push_job
);

  logic [15:0] crc_r, crc_nxt;
  logic        esc_r, esc_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [7:0]  hold_r [2];
  logic [7:0]  hold_nxt [2];
  logic [15:0] crc_upd;
  logic        accept;
  logic        have;
  logic [7:0]  dec;

  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;
  assign crc_upd  = ahdlc_pkg::crc_update(crc_r, in_data);

  always_comb begin
    crc_nxt     = crc_r;
    esc_nxt     = esc_r;
    cnt_nxt     = cnt_r;
    hold_nxt[0] = hold_r[0];
    hold_nxt[1] = hold_r[1];
    push        = 1'b0;
    push_job    = '0;
    have        = 1'b0;
    dec         = in_data;
    if (accept) begin
      if (!in_mode) begin
        push          = 1'b1;
        push_job.kind = ahdlc_pkg::JOB_TX;
        push_job.data = in_data;
        push_job.last = in_last;
        push_job.fcs  = ~crc_upd;
        crc_nxt       = in_last ? ahdlc_pkg::CRC_INIT : crc_upd;
      end else begin
        if (esc_r) begin
          esc_nxt = 1'b0;
          dec     = in_data ^ ahdlc_pkg::ESC_XOR;
          have    = 1'b1;
        end else if (in_data == ahdlc_pkg::FLAG_BYTE) begin
          cnt_nxt       = 2'd0;
          push          = 1'b1;
          push_job.kind = ahdlc_pkg::JOB_RX_END;
        end else if (in_data == ahdlc_pkg::ESC_BYTE) begin
          esc_nxt = 1'b1;
        end else begin
          have = 1'b1;
        end
        if (have) begin
          if (cnt_r == 2'd2) begin
            // Holdback full: the oldest byte is now known not to be CRC.
            push          = 1'b1;
            push_job.kind = ahdlc_pkg::JOB_RX_BYTE;
            push_job.data = hold_r[0];
            hold_nxt[0]   = hold_r[1];
            hold_nxt[1]   = dec;
          end else begin
            if (cnt_r[0]) begin
              hold_nxt[1] = dec;
            end else begin
              hold_nxt[0] = dec;
            end
            cnt_nxt = cnt_r + 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= ahdlc_pkg::CRC_INIT;
      esc_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      crc_r <= crc_nxt;
      esc_r <= esc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r[0] <= hold_nxt[0];
    hold_r[1] <= hold_nxt[1];
  end

endmodule

// ===== hw/rtl/ahdlc_queue.sv =====
// Short job queue that decouples the front part from the back part.
// Depends on ahdlc_pkg.
module ahdlc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ahdlc_pkg::job_t   push_job,
  output logic              q_ready,
  input  logic              pop,
  output logic              head_valid,
  output ahdlc_pkg::job_t   head_job
);

  ahdlc_pkg::job_t             mem_r [ahdlc_pkg::Q_DEPTH];
  logic [ahdlc_pkg::Q_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [ahdlc_pkg::Q_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [ahdlc_pkg::Q_AW:0]    count_r, count_nxt;
  logic                        do_pop;

  assign q_ready    = (count_r != (ahdlc_pkg::Q_AW+1)'(ahdlc_pkg::Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = push   ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== hw/rtl/ahdlc_back.sv =====
// Back part: expands each job into line or payload bytes, one result per cycle while the output is not stalled.
// Depends on ahdlc_pkg.
module ahdlc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  ahdlc_pkg::job_t   head_job,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_frame_end,
  output logic              out_run_last
);

  ahdlc_pkg::tx_phase_t phase_r, phase_nxt;
  logic                 sub_r, sub_nxt;
  logic                 valid_r, valid_nxt;
  logic [7:0]           byte_r;
  logic                 end_r, last_r;
  logic                 load;
  logic [7:0]           cur;
  logic                 needs_esc;
  logic                 esc_first;
  logic [7:0]           emit_byte;
  logic                 emit_end;
  logic                 emit_done;

  assign load      = head_valid && (!valid_r || out_ready);
  assign pop       = load && emit_done;
  assign out_valid = valid_r;
  assign out_byte  = byte_r;
  assign out_frame_end = end_r;
  assign out_run_last  = last_r;

  // Output decode for the current step of the head job.
  always_comb begin
    case (phase_r)
      ahdlc_pkg::PH_DATA:   cur = head_job.data;
      ahdlc_pkg::PH_FCS_LO: cur = head_job.fcs[7:0];
      ahdlc_pkg::PH_FCS_HI: cur = head_job.fcs[15:8];
      default:              cur = ahdlc_pkg::FLAG_BYTE;
    endcase
    needs_esc = (cur == ahdlc_pkg::ESC_BYTE) || (cur == ahdlc_pkg::FLAG_BYTE);
    esc_first = 1'b0;
    emit_byte = cur;
    emit_end  = 1'b0;
    emit_done = 1'b1;
    case (head_job.kind)
      ahdlc_pkg::JOB_RX_BYTE: begin
        emit_byte = head_job.data;
      end
      ahdlc_pkg::JOB_RX_END: begin
        emit_byte = 8'h00;
        emit_end  = 1'b1;
      end
      default: begin
        if (phase_r == ahdlc_pkg::PH_FLAG) begin
          emit_byte = ahdlc_pkg::FLAG_BYTE;
          emit_end  = 1'b1;
        end else if (!sub_r && needs_esc) begin
          esc_first = 1'b1;
          emit_byte = ahdlc_pkg::ESC_BYTE;
          emit_done = 1'b0;
        end else begin
          emit_byte = sub_r ? (cur ^ ahdlc_pkg::ESC_XOR) : cur;
          emit_done = (phase_r == ahdlc_pkg::PH_DATA) && !head_job.last;
        end
      end
    endcase
  end

  // Step sequencing.
  always_comb begin
    phase_nxt = phase_r;
    sub_nxt   = sub_r;
    if (load) begin
      if (emit_done) begin
        phase_nxt = ahdlc_pkg::PH_DATA;
        sub_nxt   = 1'b0;
      end else if (esc_first) begin
        sub_nxt = 1'b1;
      end else begin
        sub_nxt = 1'b0;
        case (phase_r)
          ahdlc_pkg::PH_DATA:   phase_nxt = ahdlc_pkg::PH_FCS_LO;
          ahdlc_pkg::PH_FCS_LO: phase_nxt = ahdlc_pkg::PH_FCS_HI;
          ahdlc_pkg::PH_FCS_HI: phase_nxt = ahdlc_pkg::PH_FLAG;
          default:              phase_nxt = ahdlc_pkg::PH_DATA;
        endcase
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ahdlc_pkg::PH_DATA;
      sub_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      sub_r   <= sub_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= emit_byte;
      end_r  <= emit_end;
      last_r <= emit_done;
    end
  end

endmodule

// ===== hw/rtl/async_hdlc_framer_deframer.sv =====
// Top level of the async HDLC framer/deframer: front part, job queue, back part.
// Depends on ahdlc_pkg, ahdlc_in_if/ahdlc_out_if, ahdlc_front, ahdlc_queue, ahdlc_back.
//
//   Channel  Direction  Handshake     Carries
//   in_ch    sink       valid/ready   mode, data_byte, frame_last
//   out_ch   source     valid/ready   out_byte, frame_end, run_last
//
// The back part delivers one result per cycle from a registered output while out_ch is
// not stalled; an item yields one result for a plain byte, two for an escaped transmit
// byte, and up to seven for the last byte of a transmitted frame.
// Receive items that yield nothing are taken at the front and never reach the queue.
// Reset is synchronous and active low; it reloads the CRC and empties the receive state.
// A stall on out_ch holds the output register; the two-entry queue then fills and
// in_ch.ready falls, so the front stalls only once the queue is full.
module async_hdlc_framer_deframer (
  input  logic         clk,
  input  logic         rst_n,
  ahdlc_in_if.sink     in_ch,
  ahdlc_out_if.source  out_ch
);

  logic             q_ready;
  logic             push;
  ahdlc_pkg::job_t  push_job;
  logic             pop;
  logic             head_valid;
  ahdlc_pkg::job_t  head_job;

  // The front classifies each accepted byte and updates the CRC or the receive
  // escape and holdback state; only items that yield output issue a job.
  ahdlc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_mode  (in_ch.mode),
    .in_data  (in_ch.data_byte),
    .in_last  (in_ch.frame_last),
    .q_ready  (q_ready),
    .in_ready (in_ch.ready),
    .push     (push),
    .push_job (push_job)
  );

  // The queue lets the front keep taking bytes while a frame tail is still going out.
  ahdlc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .q_ready    (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // The back steps through escapes, the inverted CRC and the closing flag.
  ahdlc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (head_valid),
    .head_job      (head_job),
    .pop           (pop),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_byte      (out_ch.out_byte),
    .out_frame_end (out_ch.frame_end),
    .out_run_last  (out_ch.run_last)
  );

`ifndef ASSERT_OFF
  // Nothing is offered on the output directly after reset.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");

  // A frame end, on either direction, is always the final result of its item.
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.frame_end) |-> out_ch.run_last)
    else $error("frame end not marked as last result");

  // Retiring a job always puts its final result into the output register.
  a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (out_ch.valid && out_ch.run_last))
    else $error("job retired without a final result");

  // The front never issues a job into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> q_ready)
    else $error("job pushed into full queue");
`endif

endmodule
